[hw/rtl/mhpq_pkg.sv]
// Package for the max-heap priority queue.
// Shared constants, status and command codes, controller/datapath structs.
// No dependencies.
package mhpq_pkg;

  localparam int unsigned DepthDef = 128;
  localparam int unsigned DataW    = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 8;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  typedef struct packed {
    logic start;
    logic up_rd;
    logic up_cmp;
    logic ext_rd;
    logic ext_ld;
    logic dn_rd;
    logic dn_cmp;
    logic load_rsp;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_extract;
    logic in_err;
    logic hole_root;
    logic up_go;
    logic cnt_zero;
    logic leaf;
    logic dn_go;
  } dp_sts_t;

endpackage

[hw/rtl/mhpq_req_if.sv]
// Request channel of the heap queue: command and key with valid/ready.
// Depends on mhpq_pkg.
interface mhpq_req_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [mhpq_pkg::DataW-1:0]   value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

[hw/rtl/mhpq_rsp_if.sv]
// Response channel of the heap queue: max value, status and count.
// Depends on mhpq_pkg.
interface mhpq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [mhpq_pkg::DataW-1:0]   max_value;
  logic [mhpq_pkg::StatusW-1:0]        status;
  logic [mhpq_pkg::CountW-1:0]         count;

  modport source (output valid, output max_value, output status, output count, input ready);
  modport sink   (input valid, input max_value, input status, input count, output ready);
endinterface

[hw/rtl/mhpq_ctrl.sv]
// Sequencer of the heap queue: walks insert sift-up and extract sift-down.
// Depends on mhpq_pkg; drives mhpq_datapath through ctrl_cmd_t.
module mhpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  mhpq_pkg::dp_sts_t   sts_i,
  output mhpq_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_EXT_RD = 3'd3;
  localparam logic [2:0] S_EXT_LD = 3'd4;
  localparam logic [2:0] S_DN_RD  = 3'd5;
  localparam logic [2:0] S_DN_CMP = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_busy;

  assign out_busy    = out_valid_q && !rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_busy;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          if (sts_i.in_err) begin
            state_d = S_DONE;
          end else if (sts_i.in_extract) begin
            state_d = S_EXT_RD;
          end else begin
            state_d = S_UP_RD;
          end
        end
      end
      S_UP_RD: begin
        cmd_o.up_rd = 1'b1;
        state_d     = sts_i.hole_root ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd_o.up_cmp = 1'b1;
        state_d      = sts_i.up_go ? S_UP_RD : S_DONE;
      end
      S_EXT_RD: begin
        cmd_o.ext_rd = 1'b1;
        state_d      = S_EXT_LD;
      end
      S_EXT_LD: begin
        cmd_o.ext_ld = 1'b1;
        state_d      = sts_i.cnt_zero ? S_DONE : S_DN_RD;
      end
      S_DN_RD: begin
        cmd_o.dn_rd = 1'b1;
        state_d     = sts_i.leaf ? S_DONE : S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd_o.dn_cmp = 1'b1;
        state_d      = sts_i.dn_go ? S_DN_RD : S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd_o.load_rsp = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_load_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_rsp |-> state_q == S_DONE && !out_busy)
    else $error("response loaded outside done state or over a pending transfer");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_rsp |=> out_valid_q && state_q == S_IDLE)
    else $error("response load did not raise valid");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q != S_IDLE)
    else $error("accepted request did not leave idle");
`endif

endmodule

[hw/rtl/mhpq_datapath.sv]
// Datapath of the heap queue: key store, moving key, hole index, count, result.
// Depends on mhpq_pkg; sequenced by mhpq_ctrl.
module mhpq_datapath #(
  parameter int unsigned DEPTH = mhpq_pkg::DepthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mhpq_pkg::ctrl_cmd_t                   cmd_i,
  output mhpq_pkg::dp_sts_t                     sts_o,
  input  logic                                  req_command_i,
  input  logic signed [mhpq_pkg::DataW-1:0]     req_value_i,
  output logic signed [mhpq_pkg::DataW-1:0]     rsp_max_value_o,
  output logic [mhpq_pkg::StatusW-1:0]          rsp_status_o,
  output logic [mhpq_pkg::CountW-1:0]           rsp_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = AW + 2;

  logic signed [mhpq_pkg::DataW-1:0] mem [DEPTH];

  logic [CW-1:0]                     count_q, count_d;
  logic [AW-1:0]                     hole_q, hole_d;
  logic signed [mhpq_pkg::DataW-1:0] key_q, key_d;
  logic signed [mhpq_pkg::DataW-1:0] res_q, res_d;
  logic [mhpq_pkg::StatusW-1:0]      st_q, st_d;
  logic signed [mhpq_pkg::DataW-1:0] rd0_q, rd1_q;

  logic [AW-1:0]                     hole_dec, par_addr, rd0_addr, rd1_addr, big_idx;
  logic [IW-1:0]                     lc_w, rc_w, count_ext;
  logic                              in_extract, in_err, use_r, up_go, dn_go, leaf;
  logic                              wr_en;
  logic signed [mhpq_pkg::DataW-1:0] wr_data, big;

  assign in_extract = (req_command_i == mhpq_pkg::CMD_EXTRACT);
  assign in_err     = in_extract ? (count_q == '0) : (count_q == CW'(DEPTH));

  assign hole_dec  = hole_q - AW'(1);
  assign par_addr  = hole_dec >> 1;
  assign lc_w      = {1'b0, hole_q, 1'b1};
  assign rc_w      = lc_w + IW'(1);
  assign count_ext = IW'(count_q);

  assign leaf    = (lc_w >= count_ext);
  assign up_go   = (key_q > rd0_q);
  assign use_r   = (rc_w < count_ext) && (rd1_q > rd0_q);
  assign big     = use_r ? rd1_q : rd0_q;
  assign big_idx = use_r ? rc_w[AW-1:0] : lc_w[AW-1:0];
  assign dn_go   = (big > key_q);

  assign sts_o.in_extract = in_extract;
  assign sts_o.in_err     = in_err;
  assign sts_o.hole_root  = (hole_q == '0);
  assign sts_o.up_go      = up_go;
  assign sts_o.cnt_zero   = (count_q == '0);
  assign sts_o.leaf       = leaf;
  assign sts_o.dn_go      = dn_go;

  assign rd0_addr = cmd_i.ext_rd ? '0 : (cmd_i.up_rd ? par_addr : lc_w[AW-1:0]);
  assign rd1_addr = cmd_i.ext_rd ? count_q[AW-1:0] : rc_w[AW-1:0];

  // Hole-based sift: the moving key is written once, where it settles.
  assign wr_en = (cmd_i.up_rd && (hole_q == '0)) || cmd_i.up_cmp
              || (cmd_i.dn_rd && leaf) || cmd_i.dn_cmp;

  always_comb begin
    if (cmd_i.up_cmp && up_go) begin
      wr_data = rd0_q;
    end else if (cmd_i.dn_cmp && dn_go) begin
      wr_data = big;
    end else begin
      wr_data = key_q;
    end
  end

  always_comb begin
    count_d = count_q;
    hole_d  = hole_q;
    key_d   = key_q;
    res_d   = res_q;
    st_d    = st_q;
    if (cmd_i.start) begin
      key_d = req_value_i;
      res_d = '0;
      if (in_err) begin
        st_d = in_extract ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_FULL;
      end else begin
        st_d = mhpq_pkg::ST_OK;
        if (in_extract) begin
          count_d = count_q - CW'(1);
          hole_d  = '0;
        end else begin
          count_d = count_q + CW'(1);
          hole_d  = count_q[AW-1:0];
        end
      end
    end
    if (cmd_i.up_cmp && up_go) begin
      hole_d = par_addr;
    end
    if (cmd_i.ext_ld) begin
      res_d = rd0_q;
      key_d = rd1_q;
    end
    if (cmd_i.dn_cmp && dn_go) begin
      hole_d = big_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    rd0_q <= mem[rd0_addr];
    rd1_q <= mem[rd1_addr];
    if (wr_en) begin
      mem[hole_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q <= hole_d;
    key_q  <= key_d;
    res_q  <= res_d;
    st_q   <= st_d;
    if (cmd_i.load_rsp) begin
      rsp_max_value_o <= res_q;
      rsp_status_o    <= st_q;
      rsp_count_o     <= mhpq_pkg::CountW'(count_q);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above depth");
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start && !in_err && !in_extract |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the count by one");
  a_hole_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.up_rd || cmd_i.up_cmp || cmd_i.dn_rd || cmd_i.dn_cmp) |-> CW'(hole_q) < count_q)
    else $error("hole outside the occupied slots");
`endif

endmodule

[hw/rtl/max_heap_priority_queue_core.sv]
// Max-heap priority queue top level: controller plus datapath with key store.
// Depends on mhpq_pkg, mhpq_req_if, mhpq_rsp_if, mhpq_ctrl, mhpq_datapath.
//
//   channel  direction  payload                       transfer when
//   req_i    in         command, value                valid && ready
//   rsp_o    out        max_value, status, count      valid && ready
//
// After a request is accepted, an insert alternates S_UP_RD and S_UP_CMP while the key
// climbs toward the root; an extract reads root and last slot (S_EXT_RD, S_EXT_LD)
// and, unless that empties the heap, alternates S_DN_RD and S_DN_CMP as the key sinks
// (at most log2(DEPTH) levels); errors go straight to S_DONE, which stalls on rsp_o.
// Reset clears the count and control; the key store needs no clearing.
// A finished result waits in the output register; a new request is taken
// once the block is back in idle, and only completion stalls on rsp_o.
module max_heap_priority_queue_core #(
  parameter int unsigned DEPTH = mhpq_pkg::DepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mhpq_req_if.sink    req_i,
  mhpq_rsp_if.source  rsp_o
);

  mhpq_pkg::ctrl_cmd_t cmd;
  mhpq_pkg::dp_sts_t   sts;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mhpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_command_i   (req_i.command),
    .req_value_i     (req_i.value),
    .rsp_max_value_o (rsp_o.max_value),
    .rsp_status_o    (rsp_o.status),
    .rsp_count_o     (rsp_o.count)
  );

endmodule
